@@ design/fixed_point_q24_8_alu_assert.svh @@
// Assertion macros used by the checker file.
`ifndef FIXED_POINT_Q24_8_ALU_ASSERT_SVH
`define FIXED_POINT_Q24_8_ALU_ASSERT_SVH

// Implication checked on every edge outside reset.
`define FQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define FQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/fq_alu_pkg.sv @@
package fq_alu_pkg;

  localparam int unsigned FracBits = 8;
  localparam int unsigned Width    = 32;
  // dividend is an operand magnitude shifted left by the fraction bits
  localparam int unsigned DivWidth = Width + FracBits;

  typedef enum logic [3:0] {
    CmdAdd     = 4'd0,
    CmdSub     = 4'd1,
    CmdMul     = 4'd2,
    CmdDiv     = 4'd3,
    CmdGt      = 4'd4,
    CmdLt      = 4'd5,
    CmdGe      = 4'd6,
    CmdLe      = 4'd7,
    CmdEq      = 4'd8,
    CmdNe      = 4'd9,
    CmdMin     = 4'd10,
    CmdMax     = 4'd11,
    CmdInc     = 4'd12,
    CmdDec     = 4'd13,
    CmdFromInt = 4'd14,
    CmdToInt   = 4'd15
  } cmd_e;

  // result value, compare flag and command, carried alongside the divider
  typedef struct packed {
    cmd_e              cmd;
    logic [Width-1:0]  value;
    logic              cmp;
  } simple_t;

  // one restoring divider lane
  typedef struct packed {
    logic [DivWidth-1:0] rem;
    logic [DivWidth-1:0] quo;
    logic [Width-1:0]    dvs;
    logic                neg;
    logic                dz;
  } div_lane_t;

  // everything one pipeline stage holds
  typedef struct packed {
    simple_t          s;
    div_lane_t        d;
    logic [Width-1:0] ma;
    logic [Width-1:0] mb;
  } pipe_t;

endpackage

@@ design/fixed_point_q24_8_alu.sv @@
// Signed Q24.8 fixed-point ALU.
// Input channel: cmd_i, operand_a_i, operand_b_i with in_valid_i / in_ready_o.
// Output channel: result_value_o, compare_true_o, divide_by_zero_o with
// out_valid_o / out_ready_i. One result beat per input beat, in order.
// Throughput: one beat per cycle while the receiver is not stalling; every operation
// walks the same pipeline of 43 register stages, set by the restoring divider,
// one quotient bit per stage, 40 stages.
// The multiply runs in the stage after entry, on registered operands.
// Reset clears all valid bits; the pipeline is empty afterwards.
// When the receiver stalls, each stage holds while its successor cannot take a beat,
// so stalls back up stage by stage and in_ready_o falls only once the
// pipeline is full; no beat is lost or repeated.
module fixed_point_q24_8_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  cmd_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] result_value_o,
  output logic        compare_true_o,
  output logic        divide_by_zero_o
);
  localparam int unsigned W  = fq_alu_pkg::Width;
  localparam int unsigned DW = fq_alu_pkg::DivWidth;
  localparam int unsigned NS = DW + 2;

  fq_alu_pkg::pipe_t  st_d  [NS+1];
  fq_alu_pkg::pipe_t  st_q  [NS+1];
  logic [NS+1:0]      vld;
  logic [NS+1:0]      rdy;

  // entry: combinational ops, divider setup, operands for the multiplier
  always_comb begin
    fq_alu_pkg::cmd_e c;
    logic gt;
    logic [W-1:0] a, b, ua, ub;
    c  = fq_alu_pkg::cmd_e'(cmd_i);
    a  = operand_a_i;
    b  = operand_b_i;
    gt = operand_a_i > operand_b_i;
    ua = a[W-1] ? (~a + 1'b1) : a;
    ub = b[W-1] ? (~b + 1'b1) : b;
    st_d[0] = '0;
    st_d[0].s.cmd = c;
    st_d[0].ma = a;
    st_d[0].mb = b;
    unique case (c)
      fq_alu_pkg::CmdAdd:     st_d[0].s.value = a + b;
      fq_alu_pkg::CmdSub:     st_d[0].s.value = a - b;
      fq_alu_pkg::CmdGt:      st_d[0].s.cmp = gt;
      fq_alu_pkg::CmdLt:      st_d[0].s.cmp = operand_a_i < operand_b_i;
      fq_alu_pkg::CmdGe:      st_d[0].s.cmp = !(operand_a_i < operand_b_i);
      fq_alu_pkg::CmdLe:      st_d[0].s.cmp = !gt;
      fq_alu_pkg::CmdEq:      st_d[0].s.cmp = a == b;
      fq_alu_pkg::CmdNe:      st_d[0].s.cmp = a != b;
      fq_alu_pkg::CmdMin:     st_d[0].s.value = gt ? b : a;
      fq_alu_pkg::CmdMax:     st_d[0].s.value = gt ? a : b;
      fq_alu_pkg::CmdInc:     st_d[0].s.value = a + 1'b1;
      fq_alu_pkg::CmdDec:     st_d[0].s.value = a - 1'b1;
      fq_alu_pkg::CmdFromInt: st_d[0].s.value = a << fq_alu_pkg::FracBits;
      fq_alu_pkg::CmdToInt:   st_d[0].s.value = W'(operand_a_i >>> fq_alu_pkg::FracBits);
      default:                st_d[0].s.value = '0;
    endcase
    // divider setup: magnitudes, dividend shifted into the quotient register
    st_d[0].d.quo = {ua, {fq_alu_pkg::FracBits{1'b0}}};
    st_d[0].d.dvs = ub;
    st_d[0].d.neg = a[W-1] ^ b[W-1];
    st_d[0].d.dz  = (b == '0);
  end

  // stage 1 does the multiply; stages 2..DW+1 each retire one quotient bit
  for (genvar i = 1; i <= NS; i++) begin : g_st
    always_comb begin
      logic [DW:0] trial;
      logic [DW-1:0] rem;
      logic signed [2*W-1:0] prod;
      st_d[i] = st_q[i-1];
      rem = {st_q[i-1].d.rem[DW-2:0], st_q[i-1].d.quo[DW-1]};
      trial = {1'b0, rem} - {{(DW+1-W){1'b0}}, st_q[i-1].d.dvs};
      prod = $signed(st_q[i-1].ma) * $signed(st_q[i-1].mb);
      if (i == 1) begin
        if (st_q[0].s.cmd == fq_alu_pkg::CmdMul) begin
          st_d[i].s.value = W'(prod >>> fq_alu_pkg::FracBits);
        end
      end else if (i <= DW + 1) begin
        st_d[i].d.quo = {st_q[i-1].d.quo[DW-2:0], !trial[DW]};
        st_d[i].d.rem = trial[DW] ? rem : trial[DW-1:0];
      end else begin
        // final: sign fix and result select for divide
        if (st_q[i-1].s.cmd == fq_alu_pkg::CmdDiv) begin
          st_d[i].s.value = st_q[i-1].d.dz ? '0 :
            (st_q[i-1].d.neg ? W'(~st_q[i-1].d.quo + 1'b1) : st_q[i-1].d.quo[W-1:0]);
        end
      end
    end
  end

  assign vld[0]     = in_valid_i;
  assign in_ready_o = rdy[0];
  assign rdy[NS+1]  = out_ready_i;
  for (genvar i = 0; i <= NS; i++) begin : g_reg
    fq_alu_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[i]),
      .ready_o (rdy[i]),
      .data_i  (st_d[i]),
      .valid_o (vld[i+1]),
      .ready_i (rdy[i+1]),
      .data_o  (st_q[i])
    );
  end

  assign out_valid_o      = vld[NS+1];
  assign result_value_o   = st_q[NS].s.value;
  assign compare_true_o   = st_q[NS].s.cmp;
  assign divide_by_zero_o = (st_q[NS].s.cmd == fq_alu_pkg::CmdDiv) && st_q[NS].d.dz;
endmodule

@@ design/fq_alu_stage.sv @@
// One pipeline stage with valid bit and per-stage stall.
module fq_alu_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  fq_alu_pkg::pipe_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output fq_alu_pkg::pipe_t data_o
);
  logic              valid_q;
  fq_alu_pkg::pipe_t data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end
endmodule

@@ design/fq_alu_checker.sv @@
`include "fixed_point_q24_8_alu_assert.svh"
// Port-level checks on the ALU.
module fq_alu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] result_value_o,
  input logic        compare_true_o,
  input logic        divide_by_zero_o
);
  // a stalled result beat holds
  `FQ_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(result_value_o))
  // flags never both set
  `FQ_ASSERT_IMP(a_flags, clk_i, rst_ni, out_valid_o, !(compare_true_o && divide_by_zero_o))
  // a true compare result carries zero value
  `FQ_ASSERT_IMP(a_cmp_zero, clk_i, rst_ni, out_valid_o && compare_true_o, result_value_o == '0)
  // divide by zero gives zero
  `FQ_ASSERT_IMP(a_dz_zero, clk_i, rst_ni, out_valid_o && divide_by_zero_o, result_value_o == '0)
endmodule

bind fixed_point_q24_8_alu fq_alu_checker u_fq_alu_checker (.*);

@@ sim/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = 42;
  localparam int WatchLimit = 5000;

  typedef struct {
    fq_alu_pkg::cmd_e   cmd;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } alu_op_t;

  typedef struct {
    logic signed [31:0] value;
    logic               cmp;
    logic               dz;
  } alu_res_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o;
  logic [3:0] cmd_i;
  logic signed [31:0] operand_a_i, operand_b_i;
  logic out_valid_o, out_ready_i;
  logic signed [31:0] result_value_o;
  logic compare_true_o, divide_by_zero_o;

  alu_op_t  op_q[$];
  alu_res_t want_q[$];
  int errors = 0;
  bit no_idle = 0;
  bit drain_req = 0;
  int hold_left = 0;
  bit hold_done = 0;
  int accepted = 0;

  fixed_point_q24_8_alu u_top (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // predicted result of one operation
  function automatic alu_res_t alu_predict(alu_op_t op);
    alu_res_t r;
    logic signed [63:0] p, num, q;
    r.value = '0;
    r.cmp = 0;
    r.dz = 0;
    case (op.cmd)
      fq_alu_pkg::CmdAdd: r.value = op.a + op.b;
      fq_alu_pkg::CmdSub: r.value = op.a - op.b;
      fq_alu_pkg::CmdMul: begin
        p = 64'(op.a) * 64'(op.b);
        r.value = 32'(p >>> fq_alu_pkg::FracBits);
      end
      fq_alu_pkg::CmdDiv: begin
        if (op.b == 0) r.dz = 1;
        else begin
          num = 64'(op.a) <<< fq_alu_pkg::FracBits;
          q = num / 64'(op.b);
          r.value = 32'(q);
        end
      end
      fq_alu_pkg::CmdGt: r.cmp = op.a > op.b;
      fq_alu_pkg::CmdLt: r.cmp = op.a < op.b;
      fq_alu_pkg::CmdGe: r.cmp = op.a >= op.b;
      fq_alu_pkg::CmdLe: r.cmp = op.a <= op.b;
      fq_alu_pkg::CmdEq: r.cmp = op.a == op.b;
      fq_alu_pkg::CmdNe: r.cmp = op.a != op.b;
      fq_alu_pkg::CmdMin: r.value = (op.a > op.b) ? op.b : op.a;
      fq_alu_pkg::CmdMax: r.value = (op.a > op.b) ? op.a : op.b;
      fq_alu_pkg::CmdInc: r.value = op.a + 1;
      fq_alu_pkg::CmdDec: r.value = op.a - 1;
      fq_alu_pkg::CmdFromInt: r.value = op.a <<< fq_alu_pkg::FracBits;
      default: r.value = op.a >>> fq_alu_pkg::FracBits;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'(int'($urandom_range(0, 8)) - 4);
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'(int'($urandom_range(0, 8192)) - 4096);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_op(fq_alu_pkg::cmd_e c, logic [31:0] a, logic [31:0] b);
    alu_op_t op;
    op.cmd = c;
    op.a = a;
    op.b = b;
    op_q.push_back(op);
  endtask

  // stimulus
  initial begin
    logic [31:0] edge_v[6];
    fq_alu_pkg::cmd_e c;
    edge_v = '{32'h0, 32'h1, 32'hffffffff, 32'h7fffffff, 32'h80000000, 32'h100};
    for (int i = 0; i < 16; i++) begin
      c = fq_alu_pkg::cmd_e'(i);
      push_op(c, edge_v[i % 6], edge_v[(i + 3) % 6]);
    end
    push_op(fq_alu_pkg::CmdDiv, 32'h500, 32'h0);
    push_op(fq_alu_pkg::CmdDiv, 32'h80000000, 32'hffffffff);
    push_op(fq_alu_pkg::CmdDiv, 32'hfffffd00, 32'h200);
    push_op(fq_alu_pkg::CmdMul, 32'h80000000, 32'h80000000);
    push_op(fq_alu_pkg::CmdEq, 32'h1234, 32'h1234);
    push_op(fq_alu_pkg::CmdToInt, 32'hffffff01, 32'h0);
    push_op(fq_alu_pkg::CmdFromInt, 32'h00ffffff, 32'hffffffff);
    for (int i = 0; i < 1400; i++) begin
      c = fq_alu_pkg::cmd_e'($urandom_range(0, 15));
      push_op(c, rand_operand(),
              (c == fq_alu_pkg::CmdDiv && $urandom_range(0, 15) == 0)
              ? 32'h0 : rand_operand());
    end
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 0;
      cmd_i <= '0;
      operand_a_i <= '0;
      operand_b_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        want_q.push_back(alu_predict(op_q.pop_front()));
        accepted++;
      end
      if (!(in_valid_i && !in_ready_o)) begin
        // pause once until everything has drained
        if (accepted == 600 && !drain_req) drain_req = 1;
        if (drain_req && accepted == 600 && want_q.size() != 0) begin
          in_valid_i <= 0;
        end else if (op_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= 19)) begin
          in_valid_i <= 1;
          cmd_i <= op_q[0].cmd;
          operand_a_i <= op_q[0].a;
          operand_b_i <= op_q[0].b;
        end else begin
          in_valid_i <= 0;
        end
      end
    end
  end

  // receiver stall pattern and checker
  always @(posedge clk_i or negedge rst_ni) begin
    alu_res_t w;
    if (!rst_ni) begin
      out_ready_i <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (want_q.size() == 0) begin
          $display("%0t: unexpected beat value=%h", $time, result_value_o);
          errors++;
        end else begin
          w = want_q.pop_front();
          if (w.value !== result_value_o || w.cmp !== compare_true_o ||
              w.dz !== divide_by_zero_o) begin
            $display("%0t: expected %h/%b/%b actual %h/%b/%b", $time, w.value,
                     w.cmp, w.dz, result_value_o, compare_true_o, divide_by_zero_o);
            errors++;
          end
        end
      end
      // one long hold-off to fill the pipe
      if (!hold_done && accepted >= 200) begin
        hold_done = 1;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 0;
      end else begin
        out_ready_i <= no_idle || $urandom_range(0, 99) >= 19;
      end
    end
  end

  // long stretch without idling
  always @(posedge clk_i) no_idle <= (accepted >= 900 && accepted < 1200);

  initial begin
    int quiet;
    rst_ni = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    quiet = 0;
    while ((op_q.size() > 0 || want_q.size() > 0) && quiet < WatchLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    if (quiet >= WatchLimit) begin
      $display("fixed_point_q24_8_alu: mismatch");
    end else begin
      repeat (Latency + 10) @(posedge clk_i);
      if (errors == 0) $display("fixed_point_q24_8_alu: match");
      else $display("fixed_point_q24_8_alu: mismatch");
    end
    $finish;
  end
endmodule
